>>> hdl/qlh_pkg.sv
`timescale 1ns / 1ps

package qlh_pkg;

  // Histogram geometry
  localparam int unsigned SLOT_COUNT  = 32;
  localparam int unsigned LANES       = 4;
  localparam int unsigned SLOT_W      = $clog2(SLOT_COUNT);
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned LOG_W       = 5;
  localparam int unsigned HIST_W      = 2;
  localparam int unsigned READ_SLOT_W = 5;
  localparam int unsigned RANGE_W     = READ_SLOT_W + 1;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic {
    MODE_SAMPLE = 1'b0,
    MODE_READ   = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EN_SEND       = 2'd0,
    CFG_EN_CONGESTION = 2'd1,
    CFG_EN_RECEIVE    = 2'd2,
    CFG_EN_THRESHOLD  = 2'd3
  } cfg_idx_e;

  // Lane numbers, in histogram order
  localparam int unsigned LANE_SEND       = 0;
  localparam int unsigned LANE_CONGESTION = 1;
  localparam int unsigned LANE_RECEIVE    = 2;
  localparam int unsigned LANE_THRESHOLD  = 3;

  // Per-lane request issued at the input transfer
  typedef struct packed {
    logic              inc;
    logic [SLOT_W-1:0] addr;
  } lane_req_t;

endpackage

>>> hdl/qlh_slot_enc.sv
`timescale 1ns / 1ps

// floor(log2) of a 32-bit value, clamped to the last slot
module qlh_slot_enc (
  input  logic [qlh_pkg::VALUE_W-1:0] value_i,
  output logic [qlh_pkg::SLOT_W-1:0]  slot_o,
  output logic                        nonzero_o
);

  logic [qlh_pkg::VALUE_W-1:0] v;
  logic [qlh_pkg::LOG_W-1:0]   msb;

  // binary search for the leading one, five halving steps
  always_comb begin
    v   = value_i;
    msb = '0;
    if (v[31:16] != 16'd0) begin
      msb[4] = 1'b1;
      v      = v >> 16;
    end
    if (v[15:8] != 8'd0) begin
      msb[3] = 1'b1;
      v      = v >> 8;
    end
    if (v[7:4] != 4'd0) begin
      msb[2] = 1'b1;
      v      = v >> 4;
    end
    if (v[3:2] != 2'd0) begin
      msb[1] = 1'b1;
      v      = v >> 2;
    end
    if (v[1]) begin
      msb[0] = 1'b1;
    end
  end

  assign slot_o = (msb >= qlh_pkg::LOG_W'(qlh_pkg::SLOT_COUNT - 1))
                ? qlh_pkg::SLOT_W'(qlh_pkg::SLOT_COUNT - 1)
                : msb[qlh_pkg::SLOT_W-1:0];

  assign nonzero_o = |value_i;

endmodule

>>> hdl/qlh_lane.sv
`timescale 1ns / 1ps

// One histogram: counter memory, per-slot valid bits, read-modify-write
// with forwarding of the write made at the same edge as the read.
module qlh_lane (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  qlh_pkg::lane_req_t          req_i,
  input  logic                        commit_i,
  output logic [qlh_pkg::COUNT_W-1:0] base_o
);

  logic [qlh_pkg::COUNT_W-1:0] mem [qlh_pkg::SLOT_COUNT];
  logic [qlh_pkg::SLOT_COUNT-1:0] slot_vld_q;

  logic [qlh_pkg::COUNT_W-1:0] rd_data_q;
  logic                        rd_vld_q;
  logic                        fwd_hit_q;
  logic [qlh_pkg::COUNT_W-1:0] fwd_data_q;
  logic                        inc_q;
  logic [qlh_pkg::SLOT_W-1:0]  addr_q;

  logic                        wr_en;
  logic [qlh_pkg::COUNT_W-1:0] wr_data;

  assign base_o  = fwd_hit_q ? fwd_data_q
                 : (rd_vld_q ? rd_data_q : '0);
  assign wr_en   = commit_i & inc_q;
  assign wr_data = base_o + qlh_pkg::COUNT_W'(1);

  // memory port: registered read, one write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[addr_q] <= wr_data;
    end
    if (load_i) begin
      rd_data_q  <= mem[req_i.addr];
      fwd_data_q <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      fwd_hit_q  <= 1'b0;
      inc_q      <= 1'b0;
      addr_q     <= '0;
    end else begin
      if (wr_en) begin
        slot_vld_q[addr_q] <= 1'b1;
      end
      if (load_i) begin
        rd_vld_q  <= slot_vld_q[req_i.addr];
        fwd_hit_q <= wr_en && (addr_q == req_i.addr);
        inc_q     <= req_i.inc;
        addr_q    <= req_i.addr;
      end
    end
  end

endmodule

>>> hdl/quad_log2_histogram.sv
`timescale 1ns / 1ps

// Four-lane log2 histogram of TCP window samples.
//
// Input channel (in_valid_i / in_ready_o): one item per transfer. With
// mode_i = sample, each enabled, nonzero window value bumps the counter at
// slot floor(log2(value)), clamped to the last slot, of its own histogram;
// the result carries slot_count_o = 0. With mode_i = read, the counter at
// read_histogram_i / read_slot_i is returned unchanged (0 for a slot past
// the end). Every input transfer yields exactly one output transfer.
// Output channel (out_valid_o / out_ready_i): result is registered.
// Config channel (cfg_valid_i / cfg_ready_o): always ready; index 0..3 sets
// the enable of the send, congestion, receive and threshold histograms.
// Result path: input stage, then output register. Throughput: one item
// per cycle while results are taken, set by the read-modify-write on each
// lane's 32-entry counter memory (registered read plus write-to-read forwarding).
// Reset: enables set to 1, per-slot valid bits cleared so every counter
// reads zero at once; no clearing pass, items are taken right after reset.
// Stall: while out_ready_i is low one result waits in the output register
// and one more item may sit in the input stage; in_ready_o then drops.
module quad_log2_histogram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [qlh_pkg::VALUE_W-1:0]     send_window_i,
  input  logic [qlh_pkg::VALUE_W-1:0]     congestion_window_i,
  input  logic [qlh_pkg::VALUE_W-1:0]     receive_window_i,
  input  logic [qlh_pkg::VALUE_W-1:0]     slow_start_threshold_i,
  input  logic [qlh_pkg::HIST_W-1:0]      read_histogram_i,
  input  logic [qlh_pkg::READ_SLOT_W-1:0] read_slot_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [qlh_pkg::COUNT_W-1:0]     slot_count_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [qlh_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic                            cfg_data_i
);

  logic [qlh_pkg::LANES-1:0] enable_q, enable_d;

  // input stage control
  logic                       s1_valid_q, s1_valid_d;
  qlh_pkg::mode_e             mode_q;
  logic [qlh_pkg::HIST_W-1:0] hist_q;
  logic                       range_ok_q;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [qlh_pkg::COUNT_W-1:0] slot_count_q, slot_count_d;

  logic in_xfer, out_free, s1_go, range_ok;

  logic [qlh_pkg::VALUE_W-1:0] lane_value [qlh_pkg::LANES];
  logic [qlh_pkg::SLOT_W-1:0]  lane_slot  [qlh_pkg::LANES];
  logic [qlh_pkg::LANES-1:0]   lane_nz;
  qlh_pkg::lane_req_t          lane_req   [qlh_pkg::LANES];
  logic [qlh_pkg::COUNT_W-1:0] lane_base  [qlh_pkg::LANES];

  assign cfg_ready_o = 1'b1;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_go      = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_xfer    = in_valid_i && in_ready_o;

  assign range_ok = {1'b0, read_slot_i} < qlh_pkg::RANGE_W'(qlh_pkg::SLOT_COUNT);

  assign lane_value[qlh_pkg::LANE_SEND]       = send_window_i;
  assign lane_value[qlh_pkg::LANE_CONGESTION] = congestion_window_i;
  assign lane_value[qlh_pkg::LANE_RECEIVE]    = receive_window_i;
  assign lane_value[qlh_pkg::LANE_THRESHOLD]  = slow_start_threshold_i;

  for (genvar l = 0; l < qlh_pkg::LANES; l++) begin : g_lane
    qlh_slot_enc u_enc (
      .value_i   (lane_value[l]),
      .slot_o    (lane_slot[l]),
      .nonzero_o (lane_nz[l])
    );

    // read items address every lane at the read slot; only one is used
    always_comb begin
      if (qlh_pkg::mode_e'(mode_i) == qlh_pkg::MODE_READ) begin
        lane_req[l].inc  = 1'b0;
        lane_req[l].addr = read_slot_i[qlh_pkg::SLOT_W-1:0];
      end else begin
        lane_req[l].inc  = enable_q[l] && lane_nz[l];
        lane_req[l].addr = lane_slot[l];
      end
    end

    qlh_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .load_i   (in_xfer),
      .req_i    (lane_req[l]),
      .commit_i (s1_go),
      .base_o   (lane_base[l])
    );
  end

  // config writes
  always_comb begin
    enable_d = enable_q;
    if (cfg_valid_i) begin
      unique case (qlh_pkg::cfg_idx_e'(cfg_index_i))
        qlh_pkg::CFG_EN_SEND:       enable_d[qlh_pkg::LANE_SEND]       = cfg_data_i;
        qlh_pkg::CFG_EN_CONGESTION: enable_d[qlh_pkg::LANE_CONGESTION] = cfg_data_i;
        qlh_pkg::CFG_EN_RECEIVE:    enable_d[qlh_pkg::LANE_RECEIVE]    = cfg_data_i;
        qlh_pkg::CFG_EN_THRESHOLD:  enable_d[qlh_pkg::LANE_THRESHOLD]  = cfg_data_i;
        default:                    enable_d = enable_q;
      endcase
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end

    out_valid_d  = out_valid_q;
    slot_count_d = slot_count_q;
    if (s1_go) begin
      out_valid_d  = 1'b1;
      slot_count_d = (mode_q == qlh_pkg::MODE_READ && range_ok_q)
                   ? lane_base[hist_q] : '0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= '1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= qlh_pkg::MODE_SAMPLE;
    end else begin
      enable_q    <= enable_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (in_xfer) begin
        mode_q <= qlh_pkg::mode_e'(mode_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      hist_q     <= read_histogram_i;
      range_ok_q <= range_ok;
    end
    slot_count_q <= slot_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign slot_count_o = slot_count_q;

endmodule

>>> hdl/qlh_checker.sv
`timescale 1ns / 1ps

module qlh_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [qlh_pkg::COUNT_W-1:0] slot_count_o
);

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(slot_count_o))
    else $error("result changed while stalled");

  // an empty output register never blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with output empty");

  // a new result comes from an input transfer through the input stage and output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without matching input transfer");

  // reset seen at an edge leaves the output register empty
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind quad_log2_histogram qlh_checker u_qlh_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .slot_count_o (slot_count_o)
);

>>> tb/sv/quad_log2_histogram_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the four-lane log2 histogram.
// Flow: reset, a short table of directed items, then random phases. Each phase
// drains the block, rewrites all four lane enables, then streams random
// sample/read items in bursts. A local model tracks the counters and enables.
// Scoreboard checks every output transfer in order against that model.
module quad_log2_histogram_tb;

  localparam int unsigned DRAIN_CYCLES    = 8;       // settle time after the drain, with slack
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 204;
  localparam int unsigned DIRECTED_N      = 22;

  // One input item plus an optional hand-written expected count.
  typedef struct packed {
    qlh_pkg::mode_e                                    mode;
    logic [0:qlh_pkg::LANES-1][qlh_pkg::VALUE_W-1:0]   value;   // send, cong, recv, thresh
    logic [qlh_pkg::HIST_W-1:0]                        hist;
    logic [qlh_pkg::READ_SLOT_W-1:0]                   slot;
    logic                                              typed;   // 1: count is the expectation
    logic [qlh_pkg::COUNT_W-1:0]                       count;
  } window_item_t;

  // Receiver back-pressure styles, redrawn at random by the receiver process.
  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_RARELY,
    READY_PERIODIC
  } ready_style_e;

  // Directed table. Typed rows are the ones obvious by inspection: any
  // sample returns zero, and counters are zero right after reset.
  localparam window_item_t DIRECTED [DIRECTED_N] = '{
    // fresh counters read zero, first and last slot
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd0, 5'd0,  1'b1, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd3, 5'd31, 1'b1, 32'h0},
    // zero values are not counted
    '{qlh_pkg::MODE_SAMPLE, '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd0, 5'd0,  1'b1, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd1, 5'd0,  1'b1, 32'h0},
    // smallest nonzero value lands in slot 0
    '{qlh_pkg::MODE_SAMPLE, '{32'h1, 32'h1, 32'h1, 32'h1}, 2'd0, 5'd0,  1'b1, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd0, 5'd0,  1'b0, 32'h0},
    // all-ones clamps to the last slot
    '{qlh_pkg::MODE_SAMPLE,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      2'd0, 5'd0, 1'b1, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd0, 5'd31, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd1, 5'd31, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd2, 5'd31, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd3, 5'd31, 1'b0, 32'h0},
    // powers of two at both ends; read fields must be ignored on a sample
    '{qlh_pkg::MODE_SAMPLE, '{32'h2, 32'h3, 32'h8000_0000, 32'h4000_0000},
      2'd3, 5'd31, 1'b1, 32'h0},
    '{qlh_pkg::MODE_SAMPLE, '{32'h7FFF_FFFF, 32'h8000, 32'h10, 32'hFFFF},
      2'd2, 5'd5, 1'b1, 32'h0},
    // value fields must be ignored on a read
    '{qlh_pkg::MODE_READ,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
      2'd0, 5'd1, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd1, 5'd1,  1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd2, 5'd31, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd3, 5'd30, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd0, 5'd30, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd1, 5'd15, 1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd2, 5'd4,  1'b0, 32'h0},
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd3, 5'd15, 1'b0, 32'h0},
    // a read leaves its counter alone
    '{qlh_pkg::MODE_READ,   '{32'h0, 32'h0, 32'h0, 32'h0}, 2'd0, 5'd0,  1'b0, 32'h0}
  };

  // Enable masks per random phase, bit i = lane i. Covers all-off and all-on.
  localparam logic [qlh_pkg::LANES-1:0] PHASE_ENABLES [PHASES] = '{
    4'b1111, 4'b0000, 4'b0101, 4'b1010, 4'b0001, 4'b1000, 4'b0110, 4'b1111
  };

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                in_ready_o;
  logic                                mode_i = qlh_pkg::MODE_SAMPLE;
  logic [qlh_pkg::VALUE_W-1:0]         send_window_i = '0;
  logic [qlh_pkg::VALUE_W-1:0]         congestion_window_i = '0;
  logic [qlh_pkg::VALUE_W-1:0]         receive_window_i = '0;
  logic [qlh_pkg::VALUE_W-1:0]         slow_start_threshold_i = '0;
  logic [qlh_pkg::HIST_W-1:0]          read_histogram_i = '0;
  logic [qlh_pkg::READ_SLOT_W-1:0]     read_slot_i = '0;
  logic                                out_valid_o;
  logic                                out_ready_i = 1'b0;
  logic [qlh_pkg::COUNT_W-1:0]         slot_count_o;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [qlh_pkg::CFG_IDX_W-1:0]       cfg_index_i = qlh_pkg::CFG_EN_SEND;
  logic                                cfg_data_i = 1'b0;

  // Travels with the item in flight: hand-written expectation, if any.
  logic                                typed_pending = 1'b0;
  logic [qlh_pkg::COUNT_W-1:0]         typed_count = '0;

  // Local copy of the block state.
  logic [qlh_pkg::COUNT_W-1:0]         slot_counts [qlh_pkg::LANES][qlh_pkg::SLOT_COUNT]
                                         = '{default: '0};
  bit                                  lane_enabled [qlh_pkg::LANES] = '{default: 1'b1};
  logic [qlh_pkg::COUNT_W-1:0]         expected_counts [$];

  int unsigned                         error_count = 0;
  int unsigned                         cycle_count = 0;
  ready_style_e                        ready_style = READY_ALWAYS;
  int unsigned                         style_left = 0;

  quad_log2_histogram u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_ready_o             (in_ready_o),
    .mode_i                 (mode_i),
    .send_window_i          (send_window_i),
    .congestion_window_i    (congestion_window_i),
    .receive_window_i       (receive_window_i),
    .slow_start_threshold_i (slow_start_threshold_i),
    .read_histogram_i       (read_histogram_i),
    .read_slot_i            (read_slot_i),
    .out_valid_o            (out_valid_o),
    .out_ready_i            (out_ready_i),
    .slot_count_o           (slot_count_o),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_ready_o            (cfg_ready_o),
    .cfg_index_i            (cfg_index_i),
    .cfg_data_i             (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // Advance the local histograms by one item; returns the count the block
  // should report for it.
  function automatic logic [qlh_pkg::COUNT_W-1:0] histogram_step(input window_item_t it);
    int unsigned                 bucket;
    logic [qlh_pkg::COUNT_W-1:0] result;
    result = '0;
    if (it.mode == qlh_pkg::MODE_READ) begin
      if (it.slot < qlh_pkg::SLOT_COUNT) result = slot_counts[it.hist][it.slot];
    end else begin
      for (int l = 0; l < qlh_pkg::LANES; l++) begin
        if (lane_enabled[l] && it.value[l] != '0) begin
          // highest set bit, clamped to the top slot
          bucket = 0;
          for (int b = 1; b < qlh_pkg::VALUE_W; b++) begin
            if (it.value[l][b]) bucket = b;
          end
          if (bucket > qlh_pkg::SLOT_COUNT - 1) bucket = qlh_pkg::SLOT_COUNT - 1;
          slot_counts[l][bucket] = slot_counts[l][bucket] + 1'b1;
        end
      end
    end
    return result;
  endfunction

  // Window value with a uniformly chosen bit length, so every slot gets hits.
  // Also zero, all-ones and plain 32-bit random values.
  function automatic logic [qlh_pkg::VALUE_W-1:0] random_window();
    int unsigned                 width;
    logic [qlh_pkg::VALUE_W-1:0] top;
    width = $urandom_range(0, qlh_pkg::VALUE_W + 2);
    if (width == 0) return '0;
    if (width == qlh_pkg::VALUE_W + 1) return '1;
    if (width == qlh_pkg::VALUE_W + 2) return qlh_pkg::VALUE_W'($urandom());
    top = {{(qlh_pkg::VALUE_W-1){1'b0}}, 1'b1} << (width - 1);
    return top | (qlh_pkg::VALUE_W'($urandom()) & (top - 1'b1));
  endfunction

  function automatic window_item_t random_item();
    window_item_t it;
    it.mode = ($urandom_range(0, 9) < 4) ? qlh_pkg::MODE_READ : qlh_pkg::MODE_SAMPLE;
    for (int l = 0; l < qlh_pkg::LANES; l++) it.value[l] = random_window();
    it.hist  = qlh_pkg::HIST_W'($urandom());
    it.slot  = qlh_pkg::READ_SLOT_W'($urandom());
    it.typed = 1'b0;
    it.count = '0;
    return it;
  endfunction

  // Present one item and hold it until the transfer. Call on a rising edge;
  // returns on the edge where the item is taken.
  task automatic send_item(input window_item_t it);
    in_valid_i             <= 1'b1;
    mode_i                 <= it.mode;
    send_window_i          <= it.value[qlh_pkg::LANE_SEND];
    congestion_window_i    <= it.value[qlh_pkg::LANE_CONGESTION];
    receive_window_i       <= it.value[qlh_pkg::LANE_RECEIVE];
    slow_start_threshold_i <= it.value[qlh_pkg::LANE_THRESHOLD];
    read_histogram_i       <= it.hist;
    read_slot_i            <= it.slot;
    typed_pending          <= it.typed;
    typed_count            <= it.count;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Sender goes quiet until every expected result is back, plus settle time.
  // The first wait lets the scoreboard log the transfer of the same edge.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_counts.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all four lane enables back to back; only called with the block idle.
  task automatic apply_enables(input logic [qlh_pkg::LANES-1:0] mask);
    for (int l = 0; l < qlh_pkg::LANES; l++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= qlh_pkg::cfg_idx_e'(l);
      cfg_data_i  <= mask[l];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: out_ready_i follows a style redrawn at random each time its countdown runs out.
  always @(posedge clk_i) begin
    if (style_left == 0) begin
      ready_style <= ready_style_e'($urandom_range(0, 3));
      style_left  <= $urandom_range(16, 96);
    end else begin
      style_left  <= style_left - 1;
    end
    unique case (ready_style)
      READY_ALWAYS:   out_ready_i <= 1'b1;
      READY_MOSTLY:   out_ready_i <= ($urandom_range(0, 3) != 0);
      READY_RARELY:   out_ready_i <= ($urandom_range(0, 3) == 0);
      default:        out_ready_i <= (style_left[2:0] == 3'd0);
    endcase
  end

  // Scoreboard. Everything sampled here is the value from before the edge,
  // since all bench inputs move by nonblocking assignment.
  always @(posedge clk_i) begin : scoreboard
    window_item_t                seen;
    logic [qlh_pkg::COUNT_W-1:0] want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        lane_enabled[cfg_index_i] = cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        seen.mode                            = qlh_pkg::mode_e'(mode_i);
        seen.value[qlh_pkg::LANE_SEND]       = send_window_i;
        seen.value[qlh_pkg::LANE_CONGESTION] = congestion_window_i;
        seen.value[qlh_pkg::LANE_RECEIVE]    = receive_window_i;
        seen.value[qlh_pkg::LANE_THRESHOLD]  = slow_start_threshold_i;
        seen.hist                            = read_histogram_i;
        seen.slot                            = read_slot_i;
        seen.typed                           = 1'b0;
        seen.count                           = '0;
        want = histogram_step(seen);
        // table rows with a hand-written value override the model
        expected_counts.push_back(typed_pending ? typed_count : want);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          $error("slot_count: no result expected, got %0h", slot_count_o);
          error_count++;
        end else begin
          want = expected_counts.pop_front();
          if (slot_count_o !== want) begin
            $error("slot_count: expected %0h, actual %0h", want, slot_count_o);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, back to back, reset enables (all lanes on).
    for (int i = 0; i < DIRECTED_N; i++) send_item(DIRECTED[i]);

    // Random phases. Each starts idle so the enable writes are clean; that
    // drain is also where the sender waits out every pending result.
    for (int p = 0; p < PHASES; p++) begin
      wait_for_results();
      apply_enables(PHASE_ENABLES[p]);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        burst = $urandom_range(1, 32);
        repeat (burst) begin
          if (sent < ITEMS_PER_PHASE) begin
            send_item(random_item());
            sent++;
          end
        end
        // a third of bursts run straight into the next one
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_for_results();
    if (expected_counts.size() != 0) begin
      $error("slot_count: %0d results never arrived", expected_counts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
